@@ rtl/core/zbtrm_pkg.sv @@
package zbtrm_pkg;

  localparam int LANES      = 2;
  localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int FIFO_DEPTH = 16;
  localparam int HEAD_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int FRAMES     = 128;
  localparam int FC_W       = 8;

  localparam int ID_W  = 16;
  localparam int ETA_W = 13;
  localparam int Z0_W  = 12;

  // input word layout, per lane: valid, track_id, eta, z0
  localparam int LANE_BITS  = 1 + ID_W + ETA_W + Z0_W;
  localparam int IN_DATA_W  = ((LANES * LANE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + ID_W + 1 + 1 + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_OUTPUT_CHANNEL  = 3'd0;
  localparam logic [2:0] REG_OUT_CHANNELS    = 3'd1;
  localparam logic [2:0] REG_NUM_BINS        = 3'd2;
  localparam logic [2:0] REG_WIDTH_C0        = 3'd3;
  localparam logic [2:0] REG_WIDTH_C1        = 3'd4;
  localparam logic [2:0] REG_WIDTH_C2        = 3'd5;
  localparam logic [2:0] REG_TRUNCATE_ENABLE = 3'd6;

  typedef struct packed {
    logic [3:0]  output_channel;
    logic [4:0]  out_channels;
    logic [8:0]  num_bins;
    logic [11:0] width_c0;
    logic [15:0] width_c1;
    logic [15:0] width_c2;
    logic        truncate_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    output_channel:  4'd0,
    out_channels:    5'd2,
    num_bins:        9'd16,
    width_c0:        12'd0,
    width_c1:        16'd0,
    width_c2:        16'd0,
    truncate_enable: 1'b1
  };

  typedef struct packed {
    logic             commit;
    logic             new_event;
    logic             trunc;
    logic [LANES-1:0] kept;
  } merge_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_COMMIT
  } seq_state_e;

endpackage

@@ rtl/core/zbtrm_lane.sv @@
module zbtrm_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  zbtrm_pkg::cfg_t                     cfg_i,
  input  logic                                valid_i,
  input  logic signed [zbtrm_pkg::ETA_W-1:0]  eta_i,
  input  logic signed [zbtrm_pkg::Z0_W-1:0]   z0_i,
  output logic                                done_o,
  output logic                                kept_o
);
  import zbtrm_pkg::*;

  // restoring remainder, three dividend bits per call
  function automatic logic [4:0] mod_step3(input logic [4:0] rem, input logic [2:0] bits,
                                           input logic [4:0] oc);
    logic [5:0] r;
    r = {1'b0, rem};
    for (int i = 2; i >= 0; i--) begin
      r = {r[4:0], bits[i]};
      if (r >= {1'b0, oc}) begin
        r = r - {1'b0, oc};
      end
    end
    return r[4:0];
  endfunction

  logic [8:0]  en_q;
  logic [12:0] ae;
  logic [24:0] ae2_q;
  logic [28:0] t1_q;
  logic [40:0] t2_q;
  logic [43:0] dz;
  logic signed [44:0] z0s, alo_d, ahi_d, alo_q, ahi_q;
  logic signed [9:0]  nbs;
  logic signed [54:0] plo_q, phi_q;
  logic signed [14:0] bmin_c, bmax_c, nbm1, half;
  logic [8:0]  bmin_q, bmax_q;
  logic        ne_q;
  logic [4:0]  rem_q;
  logic [2:0]  grp;
  logic signed [5:0] dd;
  logic [4:0]  d5;
  logic [9:0]  bsel;
  logic        kept_d, kept_q;

  assign ae    = eta_i[ETA_W-1] ? 13'(-eta_i) : 13'(eta_i);
  assign dz    = (44'(cfg_i.width_c0) << 30) + (44'(t1_q) << 10) + 44'(t2_q);
  assign z0s   = {{2{z0_i[Z0_W-1]}}, z0_i, 31'b0};
  assign alo_d = z0s - $signed({1'b0, dz});
  assign ahi_d = z0s + $signed({1'b0, dz});
  assign nbs   = $signed({1'b0, cfg_i.num_bins});

  // floor divide by 2^42 is the top bits of the product
  assign half   = $signed({7'b0, cfg_i.num_bins[8:1]});
  assign nbm1   = $signed({6'b0, cfg_i.num_bins}) - 15'sd1;
  assign bmin_c = $signed({{2{plo_q[54]}}, plo_q[54:42]}) + half;
  assign bmax_c = $signed({{2{phi_q[54]}}, phi_q[54:42]}) + half;

  assign grp = en_q[4] ? bmin_q[8:6] : (en_q[5] ? bmin_q[5:3] : bmin_q[2:0]);

  always_comb begin
    dd = $signed({2'b0, cfg_i.output_channel}) - $signed({1'b0, rem_q});
    if (dd < 0) begin
      dd = dd + $signed({1'b0, cfg_i.out_channels});
    end
    d5     = dd[4:0];
    bsel   = {1'b0, bmin_q} + 10'(d5);
    kept_d = valid_i && ne_q && (cfg_i.out_channels != 5'd0)
          && ({1'b0, cfg_i.output_channel} < cfg_i.out_channels)
          && (bsel <= {1'b0, bmax_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else begin
      en_q <= {en_q[7:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ae2_q <= 25'(26'(ae) * 26'(ae));
      t1_q  <= 29'(cfg_i.width_c1) * 29'(ae);
    end
    if (en_q[0]) begin
      t2_q <= 41'(cfg_i.width_c2) * 41'(ae2_q);
    end
    if (en_q[1]) begin
      alo_q <= alo_d;
      ahi_q <= ahi_d;
    end
    if (en_q[2]) begin
      plo_q <= 55'(alo_q) * 55'(nbs);
      phi_q <= 55'(ahi_q) * 55'(nbs);
    end
    if (en_q[3]) begin
      bmin_q <= (bmin_c < 0) ? 9'd0 : bmin_c[8:0];
      bmax_q <= (bmax_c > nbm1) ? nbm1[8:0] : bmax_c[8:0];
      ne_q   <= ((bmin_c < 0) ? 15'sd0 : bmin_c) <= ((bmax_c > nbm1) ? nbm1 : bmax_c);
      rem_q  <= '0;
    end else if (en_q[4] || en_q[5] || en_q[6]) begin
      rem_q <= mod_step3(rem_q, grp, cfg_i.out_channels);
    end
    if (en_q[7]) begin
      kept_q <= kept_d;
    end
  end

  assign done_o = en_q[8];
  assign kept_o = kept_q;

endmodule

@@ rtl/core/zbtrm_merge.sv @@
module zbtrm_merge (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  zbtrm_pkg::merge_req_t                               req_i,
  input  logic [zbtrm_pkg::LANES-1:0][zbtrm_pkg::ID_W-1:0]    id_i,
  output logic                                                out_free_o,
  output logic                                                m_axis_tvalid,
  input  logic                                                m_axis_tready,
  // out_valid, out_track_id[15:0], out_source, overflow_drop, frame_limit_hit
  output logic [zbtrm_pkg::OUT_DATA_W-1:0]                    m_axis_tdata
);
  import zbtrm_pkg::*;

  localparam int VALID_BIT = 0;
  localparam int LIMIT_BIT = ID_W + 3;

  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    return (h == HEAD_W'(FIFO_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  logic [ID_W-1:0]   mem_q [LANES][FIFO_DEPTH];
  logic [ID_W-1:0]   rd_q  [LANES];
  logic [HEAD_W-1:0] head_q [LANES];
  logic [FILL_W-1:0] fill_q [LANES];
  logic [FC_W-1:0]   fc_q;

  logic [HEAD_W-1:0] head1 [LANES];
  logic [HEAD_W-1:0] head_d [LANES];
  logic [HEAD_W-1:0] wr_addr [LANES];
  logic [FILL_W-1:0] fill0 [LANES];
  logic [FILL_W-1:0] fill1 [LANES];
  logic [FILL_W-1:0] fill2 [LANES];
  logic [FILL_W-1:0] fill_d [LANES];
  logic [FILL_W:0]   wsum [LANES];
  logic [LANES-1:0]  push;
  logic [FC_W-1:0]   fc0, fc_d;
  logic              drop, found, limit, byp;
  logic [LANE_W-1:0] pick;

  logic              ld_q, got_q, drop_q, limit_q, byp_q;
  logic [LANE_W-1:0] src_q;
  logic [ID_W-1:0]   byp_id_q;
  logic              out_vld_q;
  logic [OUT_DATA_W-1:0] out_word_q;
  logic [ID_W-1:0]   out_id;

  always_comb begin
    drop = 1'b0;
    for (int c = 0; c < LANES; c++) begin
      fill0[c] = req_i.new_event ? '0 : fill_q[c];
      head1[c] = req_i.new_event ? '0 : head_q[c];
      fill1[c] = fill0[c];
      push[c]  = req_i.kept[c];
      if (req_i.kept[c]) begin
        if (req_i.trunc) begin
          if (fill0[c] >= FILL_W'(FIFO_DEPTH - 1)) begin
            head1[c] = head_inc(head1[c]);
            fill1[c] = fill0[c] - 1'b1;
            drop     = 1'b1;
          end
        end else if (fill0[c] >= FILL_W'(FIFO_DEPTH)) begin
          push[c] = 1'b0;
          drop    = 1'b1;
        end
      end
      wsum[c] = (FILL_W + 1)'(head1[c]) + (FILL_W + 1)'(fill1[c]);
      if (wsum[c] >= (FILL_W + 1)'(FIFO_DEPTH)) begin
        wsum[c] = wsum[c] - (FILL_W + 1)'(FIFO_DEPTH);
      end
      wr_addr[c] = HEAD_W'(wsum[c]);
      fill2[c]   = fill1[c] + FILL_W'(push[c]);
    end

    found = 1'b0;
    pick  = '0;
    for (int c = 0; c < LANES; c++) begin
      if (!found && fill2[c] != '0) begin
        found = 1'b1;
        pick  = LANE_W'(c);
      end
    end

    for (int c = 0; c < LANES; c++) begin
      head_d[c] = head1[c];
      fill_d[c] = fill2[c];
      if (found && pick == LANE_W'(c)) begin
        head_d[c] = head_inc(head1[c]);
        fill_d[c] = fill2[c] - 1'b1;
      end
    end
    byp = push[pick] && (fill1[pick] == '0);

    fc0   = req_i.new_event ? '0 : fc_q;
    limit = req_i.trunc && (fc0 >= FC_W'(FRAMES));
    fc_d  = (fc0 != '1) ? fc0 + 1'b1 : fc0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < LANES; c++) begin
        head_q[c] <= '0;
        fill_q[c] <= '0;
      end
      fc_q <= '0;
      ld_q <= 1'b0;
    end else begin
      ld_q <= req_i.commit;
      if (req_i.commit) begin
        for (int c = 0; c < LANES; c++) begin
          head_q[c] <= head_d[c];
          fill_q[c] <= fill_d[c];
        end
        fc_q <= fc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.commit) begin
      for (int c = 0; c < LANES; c++) begin
        if (push[c]) begin
          mem_q[c][wr_addr[c]] <= id_i[c];
        end
        rd_q[c] <= mem_q[c][head1[c]];
      end
      got_q    <= found && !limit;
      src_q    <= pick;
      byp_q    <= byp;
      byp_id_q <= id_i[pick];
      drop_q   <= drop;
      limit_q  <= limit;
    end
  end

  assign out_id = byp_q ? byp_id_q : rd_q[src_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ld_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_q) begin
      out_word_q <= OUT_DATA_W'({limit_q, drop_q,
                                 got_q ? 1'(src_q) : 1'b0,
                                 got_q ? out_id : {ID_W{1'b0}},
                                 got_q});
    end
  end

  assign out_free_o    = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_word_q;

  for (genvar g = 0; g < LANES; g++) begin : g_fill_chk
    a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      fill_q[g] <= FILL_W'(FIFO_DEPTH))
      else $error("fifo fill beyond depth");
  end

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_q |-> !out_vld_q)
    else $error("output word overwritten");

  a_limit_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_word_q[LIMIT_BIT]) |-> !out_word_q[VALID_BIT])
    else $error("track emitted beyond frame limit");

endmodule

@@ rtl/core/zbin_track_router_merge_unit.sv @@
// Z-bin track router and merger for one output channel. Each input word carries one
// tick: a new_event flag in tuser and up to one track per input lane in tdata. Both
// lanes compute their z window and bin ownership side by side in a multiply/remainder
// pipeline; a merge stage then updates the per-lane FIFOs, the frame counter and pops
// the lowest-numbered non-empty FIFO. One word is taken at a time: a new word is
// accepted only after the previous one has committed, which waits for the output
// register to drain, and each word yields exactly one output word, through a load
// flag and then the output register after its commit. Registers sit on APB at byte
// address 4*index and should be written only while no word is in flight.
module zbin_track_router_merge_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [zbtrm_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // per lane from lane 0: valid, track_id[15:0], eta[12:0], z0[11:0]; zero pad
  input  logic [zbtrm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // new_event
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_valid, out_track_id[15:0], out_source, overflow_drop, frame_limit_hit; zero pad
  output logic [zbtrm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import zbtrm_pkg::*;

  cfg_t            cfg_q;
  logic [2:0]      reg_idx;
  logic            cfg_wr;
  seq_state_e      state_q, state_d;
  logic            accept, start_q, commit, out_free;
  logic [IN_DATA_W-1:0] in_q;
  logic            new_event_q;
  logic [LANES-1:0] done, kept;
  logic [LANES-1:0][ID_W-1:0] ids;
  merge_req_t      req;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_OUTPUT_CHANNEL:  cfg_q.output_channel  <= pwdata[3:0];
        REG_OUT_CHANNELS:    cfg_q.out_channels    <= pwdata[4:0];
        REG_NUM_BINS:        cfg_q.num_bins        <= pwdata[8:0];
        REG_WIDTH_C0:        cfg_q.width_c0        <= pwdata[11:0];
        REG_WIDTH_C1:        cfg_q.width_c1        <= pwdata[15:0];
        REG_WIDTH_C2:        cfg_q.width_c2        <= pwdata[15:0];
        REG_TRUNCATE_ENABLE: cfg_q.truncate_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OUTPUT_CHANNEL:  prdata = 32'(cfg_q.output_channel);
      REG_OUT_CHANNELS:    prdata = 32'(cfg_q.out_channels);
      REG_NUM_BINS:        prdata = 32'(cfg_q.num_bins);
      REG_WIDTH_C0:        prdata = 32'(cfg_q.width_c0);
      REG_WIDTH_C1:        prdata = 32'(cfg_q.width_c1);
      REG_WIDTH_C2:        prdata = 32'(cfg_q.width_c2);
      REG_TRUNCATE_ENABLE: prdata = 32'(cfg_q.truncate_enable);
      default:             prdata = '0;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (&done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q        <= s_axis_tdata;
      new_event_q <= s_axis_tuser;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    localparam int B = g * LANE_BITS;
    assign ids[g] = in_q[B+ID_W:B+1];
    zbtrm_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start_q),
      .cfg_i   (cfg_q),
      .valid_i (in_q[B]),
      .eta_i   ($signed(in_q[B+ID_W+ETA_W:B+ID_W+1])),
      .z0_i    ($signed(in_q[B+LANE_BITS-1:B+ID_W+ETA_W+1])),
      .done_o  (done[g]),
      .kept_o  (kept[g])
    );
  end

  assign req.commit    = commit;
  assign req.new_event = new_event_q;
  assign req.trunc     = cfg_q.truncate_enable;
  assign req.kept      = kept;

  zbtrm_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .id_i          (ids),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done[0] |-> (state_q == ST_CALC))
    else $error("lane result outside calc phase");

endmodule
